### rtl/cpf_pkg.sv
// package: widths, register codes and shared types of the coulomb pair force unit
`timescale 1ns / 1ps

package cpf_pkg;

  localparam int CoordW  = 32;   // input coordinate, q16.16
  localparam int DiffW   = 33;   // separation per axis, signed
  localparam int MagW    = 32;   // separation magnitude per axis
  localparam int SqW     = 64;   // squared magnitude per axis
  localparam int SumW    = 66;   // r squared, q32.32
  localparam int RootW   = 33;   // r, q16.16
  localparam int ProdW   = 64;   // |q| * |d|
  localparam int DenW    = 99;   // r2 * r
  localparam int TermW   = 67;   // 2^32 - h*r, signed
  localparam int TmW     = 66;   // magnitude of that term
  localparam int ENumW   = 98;   // energy numerator
  localparam int FNumW   = 104;  // force numerator
  localparam int VNumW   = 56;   // virial numerator
  localparam int EDenW   = 41;   // energy denominator, r << 8
  localparam int ResW    = 48;   // q24.24 result
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 2;
  localparam int ForceShift  = 40;
  localparam int EnergyShift = 8;
  localparam int VirialShift = 24;
  localparam int OneShift    = 32;   // 1.0 in q32.32

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHARGE = 2'd0,
    REG_SHIFT  = 2'd1
  } cfg_reg_t;

  // what rides alongside the square root
  typedef struct packed {
    logic                  v;
    logic                  zero;
    logic [SumW-1:0]       s;
    logic [2:0]            dneg;
    logic [2:0][ProdW-1:0] qd;
  } front_t;

endpackage

### rtl/cpf_isqrt.sv
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module cpf_isqrt (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [cpf_pkg::SumW-1:0]   radicand,
  output logic [cpf_pkg::RootW-1:0]  root
);
  import cpf_pkg::*;

  localparam int RW = SumW + 2;

  logic [RW-1:0]    rem_q [RootW];
  logic [RootW-1:0] res_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int B = RootW - 1 - k;
    logic [RW-1:0]    rem_in;
    logic [RW-1:0]    trial;
    logic [RootW-1:0] res_in;

    if (k == 0) begin : g_first
      assign rem_in = RW'(radicand);
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    // (res + 2^b)^2 - res^2
    assign trial = (RW'(res_in) << (B + 1)) | (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= res_in | (RootW'(1) << B);
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in;
        end
      end
    end
  end

  assign root = res_q[RootW-1];

endmodule

### rtl/cpf_div_pipe.sv
// pipelined restoring divider with signed q24.24 saturation
`timescale 1ns / 1ps

module cpf_div_pipe #(
  parameter int NumW = cpf_pkg::FNumW,
  parameter int DenW = cpf_pkg::DenW
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic [NumW-1:0]          num,
  input  logic [DenW-1:0]          den,
  input  logic                     neg,
  output logic [cpf_pkg::ResW-1:0] result
);
  import cpf_pkg::*;

  localparam int QW = ResW;
  localparam int W  = ((NumW > DenW + QW) ? NumW : DenW + QW) + 1;
  localparam logic [QW-1:0] PosMax = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NegMax = {1'b1, {(QW-1){1'b0}}};

  logic [W-1:0]    rem_q [QW+1];
  logic [DenW-1:0] den_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic            neg_q [QW+1];
  logic            sat_q [QW+1];

  // quotient at or above 2^48 saturates whatever its low bits
  always_ff @(posedge clk) begin
    if (adv) begin
      rem_q[0] <= W'(num);
      den_q[0] <= den;
      quo_q[0] <= '0;
      neg_q[0] <= neg;
      sat_q[0] <= W'(num) >= (W'(den) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    localparam int B = QW - k;
    logic [W-1:0] dsh;
    assign dsh = W'(den_q[k-1]) << B;

    always_ff @(posedge clk) begin
      if (adv) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (rem_q[k-1] >= dsh) begin
          rem_q[k] <= rem_q[k-1] - dsh;
          quo_q[k] <= quo_q[k-1] | (QW'(1) << B);
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  logic big;
  assign big = sat_q[QW] | quo_q[QW][QW-1];

  always_comb begin
    if (neg_q[QW]) result = big ? NegMax : (QW'(0) - quo_q[QW]);
    else           result = big ? PosMax : quo_q[QW];
  end

endmodule

### rtl/coulomb_pair_force_unit.sv
// top level of the shifted coulomb pair force unit
`timescale 1ns / 1ps

// Shifted Coulomb force for one atom pair per item. From two Q16.16 positions the unit
// forms d = pj - pi, r2 and r = floor(sqrt(r2)), then returns the force on atom J
// q*d/(r2*r), the energy q*(1/r - shift) and the virial -q/r, all Q24.24 saturated,
// each quotient exact and truncated toward zero. Coincident atoms set zero_distance and
// give zeros. A new item is taken every cycle; the pipe has 3 front stages,
// 33 square-root stages (one root bit each), 4 product stages and 49 divider stages
// (a range check plus one quotient bit each), then the output register. The whole
// pipe holds while a finished item waits at a stalled output. charge_product and
// energy_shift are written through write_enable/write_index/write_data between items.

module coulomb_pair_force_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         write_enable,
  input  logic [cpf_pkg::CfgIdxW-1:0]  write_index,
  input  logic [cpf_pkg::CfgW-1:0]     write_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [31:0]           first_x,
  input  logic signed [31:0]           first_y,
  input  logic signed [31:0]           first_z,
  input  logic signed [31:0]           second_x,
  input  logic signed [31:0]           second_y,
  input  logic signed [31:0]           second_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [47:0]           force_x,
  output logic signed [47:0]           force_y,
  output logic signed [47:0]           force_z,
  output logic signed [47:0]           pair_energy,
  output logic signed [47:0]           virial_part,
  output logic                         zero_distance
);
  import cpf_pkg::*;

  localparam int DivLat = ResW + 1;

  // configuration registers
  logic [CfgW-1:0] charge_product;
  logic [CfgW-1:0] energy_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_product <= '0;
      energy_shift   <= '0;
    end else if (write_enable) begin
      if (write_index == REG_CHARGE) charge_product <= write_data;
      if (write_index == REG_SHIFT)  energy_shift   <= write_data;
    end
  end

  // magnitudes and signs of the constants, to be kept steady while items are in flight
  logic [MagW-1:0] qm, hm;
  logic            q_neg, q_pos, h_neg;
  assign q_neg = charge_product[CfgW-1];
  assign q_pos = !charge_product[CfgW-1] && (charge_product != '0);
  assign h_neg = energy_shift[CfgW-1];
  assign qm    = q_neg ? (MagW'(0) - charge_product) : charge_product;
  assign hm    = h_neg ? (MagW'(0) - energy_shift) : energy_shift;

  // the whole pipe moves unless the output holds an item nobody takes
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: separation per axis
  logic [2:0][CoordW-1:0] pi_c, pj_c;
  logic [2:0][DiffW-1:0]  diff;
  assign pi_c = {first_z, first_y, first_x};
  assign pj_c = {second_z, second_y, second_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {pj_c[i][CoordW-1], pj_c[i]} - {pi_c[i][CoordW-1], pi_c[i]};
    end
  end

  logic                 v1;
  logic [2:0]           dneg1;
  logic [2:0][MagW-1:0] dmag1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dneg1[i] <= diff[i][DiffW-1];
        dmag1[i] <= diff[i][DiffW-1] ? MagW'(DiffW'(0) - diff[i]) : diff[i][MagW-1:0];
      end
    end
  end

  // stage 2: squares and charge products per axis
  logic                  v2;
  logic [2:0]            dneg2;
  logic [2:0][SqW-1:0]   sq2;
  logic [2:0][ProdW-1:0] qd2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dneg2 <= dneg1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= SqW'(dmag1[i]) * SqW'(dmag1[i]);
        qd2[i] <= ProdW'(qm) * ProdW'(dmag1[i]);
      end
    end
  end

  // stage 3: r squared
  front_t f3;

  always_ff @(posedge clk) begin
    if (rst) f3.v <= 1'b0;
    else if (adv) f3.v <= v2;
    if (adv) begin
      f3.s    <= SumW'(sq2[0]) + SumW'(sq2[1]) + SumW'(sq2[2]);
      f3.zero <= (sq2[0] == '0) && (sq2[1] == '0) && (sq2[2] == '0);
      f3.dneg <= dneg2;
      f3.qd   <= qd2;
    end
  end

  // square root, with the rest of the item riding alongside
  logic [RootW-1:0] root;

  cpf_isqrt u_isqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (f3.s),
    .root     (root)
  );

  front_t dl [RootW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RootW; k++) dl[k] <= '0;
    end else if (adv) begin
      dl[0] <= f3;
      for (int k = 1; k < RootW; k++) dl[k] <= dl[k-1];
    end
  end

  front_t a;
  assign a = dl[RootW-1];

  // stage 4: partial products of r2*r and h*r
  logic                  v4, zero4;
  logic [2:0]            dneg4;
  logic [2:0][ProdW-1:0] qd4;
  logic [RootW-1:0]      r4;
  logic [SumW-1:0]       pslo4, pshi4;
  logic [MagW+RootW-1:0] hr4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= a.v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero4 <= a.zero;
      dneg4 <= a.dneg;
      qd4   <= a.qd;
      r4    <= root;
      pslo4 <= SumW'(a.s[32:0]) * SumW'(root);
      pshi4 <= SumW'(a.s[SumW-1:33]) * SumW'(root);
      hr4   <= (MagW + RootW)'(hm) * (MagW + RootW)'(root);
    end
  end

  // stage 5: r2*r and the shifted inverse-distance term 2^32 - h*r
  logic [TermW-1:0] term;
  assign term = h_neg ? ((TermW'(1) << OneShift) + TermW'(hr4))
                      : ((TermW'(1) << OneShift) - TermW'(hr4));

  logic                  v5, zero5, tneg5;
  logic [2:0]            dneg5;
  logic [2:0][ProdW-1:0] qd5;
  logic [RootW-1:0]      r5;
  logic [DenW-1:0]       den5;
  logic [TmW-1:0]        tm5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero5 <= zero4;
      dneg5 <= dneg4;
      qd5   <= qd4;
      r5    <= r4;
      den5  <= (DenW'(pshi4) << 33) + DenW'(pslo4);
      tneg5 <= term[TermW-1];
      tm5   <= term[TermW-1] ? TmW'(TermW'(0) - term) : term[TmW-1:0];
    end
  end

  // stage 6: partial products of the energy numerator
  logic                  v6, zero6, tneg6;
  logic [2:0]            dneg6;
  logic [2:0][ProdW-1:0] qd6;
  logic [RootW-1:0]      r6;
  logic [DenW-1:0]       den6;
  logic [64:0]           elo6, ehi6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero6 <= zero5;
      dneg6 <= dneg5;
      qd6   <= qd5;
      r6    <= r5;
      den6  <= den5;
      tneg6 <= tneg5;
      elo6  <= 65'(tm5[32:0]) * 65'(qm);
      ehi6  <= 65'(tm5[TmW-1:33]) * 65'(qm);
    end
  end

  // stage 7: energy numerator
  logic                  v7, zero7, tneg7;
  logic [2:0]            dneg7;
  logic [2:0][ProdW-1:0] qd7;
  logic [RootW-1:0]      r7;
  logic [DenW-1:0]       den7;
  logic [ENumW-1:0]      enum7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero7 <= zero6;
      dneg7 <= dneg6;
      qd7   <= qd6;
      r7    <= r6;
      den7  <= den6;
      tneg7 <= tneg6;
      enum7 <= (ENumW'(ehi6) << 33) + ENumW'(elo6);
    end
  end

  // five dividers in lockstep
  logic [2:0][ResW-1:0] fres;
  logic [ResW-1:0]      eres, vres;

  for (genvar i = 0; i < 3; i++) begin : g_force
    cpf_div_pipe #(
      .NumW (FNumW),
      .DenW (DenW)
    ) u_div (
      .clk    (clk),
      .adv    (adv),
      .num    (FNumW'(qd7[i]) << ForceShift),
      .den    (den7),
      .neg    (q_neg != dneg7[i]),
      .result (fres[i])
    );
  end

  cpf_div_pipe #(
    .NumW (ENumW),
    .DenW (EDenW)
  ) u_energy_div (
    .clk    (clk),
    .adv    (adv),
    .num    (enum7),
    .den    (EDenW'(r7) << EnergyShift),
    .neg    (q_neg != tneg7),
    .result (eres)
  );

  cpf_div_pipe #(
    .NumW (VNumW),
    .DenW (RootW)
  ) u_virial_div (
    .clk    (clk),
    .adv    (adv),
    .num    (VNumW'(qm) << VirialShift),
    .den    (r7),
    .neg    (q_pos),
    .result (vres)
  );

  // valid and coincidence flag follow the dividers
  logic tail_v    [DivLat];
  logic tail_zero [DivLat];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DivLat; k++) tail_v[k] <= 1'b0;
    end else if (adv) begin
      tail_v[0] <= v7;
      for (int k = 1; k < DivLat; k++) tail_v[k] <= tail_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_zero[0] <= zero7;
      for (int k = 1; k < DivLat; k++) tail_zero[k] <= tail_zero[k-1];
    end
  end

  // output register; coincident atoms force all results to zero
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= tail_v[DivLat-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_distance <= tail_zero[DivLat-1];
      force_x       <= tail_zero[DivLat-1] ? '0 : fres[0];
      force_y       <= tail_zero[DivLat-1] ? '0 : fres[1];
      force_z       <= tail_zero[DivLat-1] ? '0 : fres[2];
      pair_energy   <= tail_zero[DivLat-1] ? '0 : eres;
      virial_part   <= tail_zero[DivLat-1] ? '0 : vres;
    end
  end

  // coincident atoms report nothing but the flag
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_distance |-> force_x == '0 && force_y == '0 && force_z == '0 &&
                                   pair_energy == '0 && virial_part == '0)
    else $error("coincident atoms gave a nonzero result");

  // a waiting result freezes the input side too
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output is held");

  // zero charge gives zero everywhere
  a_no_charge: assert property (@(posedge clk) disable iff (rst)
    out_valid && charge_product == '0 |-> force_x == '0 && force_y == '0 &&
                                          force_z == '0 && pair_energy == '0 &&
                                          virial_part == '0)
    else $error("zero charge gave a nonzero result");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

### tb/sv/testbench.sv
// self-checking testbench of the coulomb pair force unit
`timescale 1ns / 1ps

module testbench;
  import cpf_pkg::*;

  // register index that lies beyond the register list, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int PipeDepth = 90;     // depth of the top-level pipeline
  localparam int StallLimit = 20000; // cycles with no handshake before giving up

  // one atom pair as it enters the unit
  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } pair_t;

  // one force result as it leaves the unit
  typedef struct {
    logic signed [47:0] fx, fy, fz, energy, virial;
    logic               zero;
  } force_t;

  // keeps a copy of the two registers and predicts the force result of each pair
  class force_scoreboard;
    logic signed [31:0] charge;
    logic signed [31:0] shift;
    force_t             awaited[$];
    int                 errors;

    function new();
      charge = '0;
      shift  = '0;
      errors = 0;
    endfunction

    function logic [47:0] clamp48(bit neg, logic [127:0] mag);
      if (!neg) return (mag > 128'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : mag[47:0];
      if (mag >= 128'h8000_0000_0000) return 48'h8000_0000_0000;
      return 48'(-mag);
    endfunction

    function force_t compute_force(pair_t p);
      logic signed [31:0]  a[3];
      logic signed [31:0]  b[3];
      logic signed [32:0]  d[3];
      logic signed [63:0]  qs, hs;
      logic [127:0]        qm, hm, m, s, r, c, den, num, tm;
      logic signed [127:0] term;
      bit                  tneg;
      force_t              f;
      a = '{p.ax, p.ay, p.az};
      b = '{p.bx, p.by, p.bz};
      for (int i = 0; i < 3; i++) d[i] = b[i] - a[i];
      f = '{fx: '0, fy: '0, fz: '0, energy: '0, virial: '0, zero: 1'b0};
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
        f.zero = 1'b1;
        return f;
      end
      qs = charge;
      hs = shift;
      qm = (qs < 0) ? -qs : qs;
      hm = (hs < 0) ? -hs : hs;
      s = '0;
      for (int i = 0; i < 3; i++) begin
        m = (d[i] < 0) ? -d[i] : d[i];
        s = s + m * m;
      end
      // floor square root, one bit at a time
      r = '0;
      for (int k = 34; k >= 0; k--) begin
        c = r | (128'd1 << k);
        if (c * c <= s) r = c;
      end
      den = s * r;
      for (int i = 0; i < 3; i++) begin
        m   = (d[i] < 0) ? -d[i] : d[i];
        num = (qm * m) << ForceShift;
        case (i)
          0: f.fx = clamp48((qs < 0) != (d[i] < 0), num / den);
          1: f.fy = clamp48((qs < 0) != (d[i] < 0), num / den);
          default: f.fz = clamp48((qs < 0) != (d[i] < 0), num / den);
        endcase
      end
      // energy term 1.0 - h*r in q32.32, may go negative
      if (hs < 0) term = $signed((128'd1 << OneShift) + hm * r);
      else term = $signed(128'd1 << OneShift) - $signed(hm * r);
      tneg = term < 0;
      tm = tneg ? -term : term;
      f.energy = clamp48((qs < 0) != tneg, (tm * qm) / (r << EnergyShift));
      f.virial = clamp48(qs > 0, (qm << VirialShift) / r);
      return f;
    endfunction

    function void note_pair(pair_t p);
      awaited = {awaited, compute_force(p)};
    endfunction

    task report(string what, logic [47:0] got, logic [47:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_force(force_t f);
      force_t w;
      if (awaited.size() == 0) begin
        errors++;
        $display("result with nothing pending");
        return;
      end
      w = awaited.pop_front();
      if (f.fx != w.fx) report("force_x", f.fx, w.fx);
      if (f.fy != w.fy) report("force_y", f.fy, w.fy);
      if (f.fz != w.fz) report("force_z", f.fz, w.fz);
      if (f.energy != w.energy) report("pair_energy", f.energy, w.energy);
      if (f.virial != w.virial) report("virial_part", f.virial, w.virial);
      if (f.zero != w.zero) report("zero_distance", 48'(f.zero), 48'(w.zero));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                write_enable;
  logic [CfgIdxW-1:0]  write_index;
  logic [CfgW-1:0]     write_data;
  logic                in_valid;
  logic                in_stall;
  logic signed [31:0]  first_x, first_y, first_z, second_x, second_y, second_z;
  logic                out_valid;
  logic                out_stall;
  logic signed [47:0]  force_x, force_y, force_z, pair_energy, virial_part;
  logic                zero_distance;

  force_scoreboard     board;
  bit                  calm;       // no idling on either side while set
  bit                  hold_req;   // asks the receiver for one long hold-off
  int                  quiet_cycles;

  coulomb_pair_force_unit dut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .pair_energy(pair_energy), .virial_part(virial_part), .zero_distance(zero_distance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function bit idle_now();
    return !calm && ($urandom_range(99) < 36);
  endfunction

  // receiver: checks each accepted result, stalls at random, holds off on request
  initial begin
    int hold_left;
    force_t f;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        f = '{fx: force_x, fy: force_y, fz: force_z, energy: pair_energy,
              virial: virial_part, zero: zero_distance};
        board.check_force(f);
      end
      if (hold_req) begin
        hold_req  <= 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // watchdog: gives up when no handshake happens for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst || write_enable)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // offer one pair, with random idle cycles first, and wait until it is taken
  task automatic send_pair(pair_t p);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    first_x  <= p.ax;
    first_y  <= p.ay;
    first_z  <= p.az;
    second_x <= p.bx;
    second_y <= p.by;
    second_z <= p.bz;
    do @(posedge clk); while (in_stall);
    board.note_pair(p);
  endtask

  // wait until every pending result is back and the pipe has drained
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (PipeDepth + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    if (idx == REG_CHARGE) board.charge = val;
    else if (idx == REG_SHIFT) board.shift = val;
    @(posedge clk);
  endtask

  // random pair: mostly close atoms, sometimes coincident or anywhere at all
  function automatic pair_t random_pair();
    pair_t p;
    int    kind, span;
    p.ax = $urandom();
    p.ay = $urandom();
    p.az = $urandom();
    kind = $urandom_range(9);
    if (kind == 0) begin
      p.bx = $urandom();
      p.by = $urandom();
      p.bz = $urandom();
    end else if (kind == 1) begin
      p.bx = p.ax;
      p.by = p.ay;
      p.bz = p.az;
    end else begin
      span = $urandom_range(24);
      p.bx = p.ax + $signed($urandom_range((1 << span) * 2) - (1 << span));
      p.by = p.ay + $signed($urandom_range((1 << span) * 2) - (1 << span));
      p.bz = p.az + $signed($urandom_range((1 << span) * 2) - (1 << span));
    end
    return p;
  endfunction

  function automatic pair_t mk_pair(logic signed [31:0] ax, ay, az, bx, by, bz);
    pair_t p;
    p = '{ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz};
    return p;
  endfunction

  localparam logic signed [31:0] Max = 32'h7FFF_FFFF;
  localparam logic signed [31:0] Min = 32'h8000_0000;
  localparam logic signed [31:0] One = 32'h0001_0000;

  initial begin
    logic [31:0] charges[8];
    logic [31:0] shifts[8];
    pair_t       corner[$];
    board        = new();
    calm         = 1'b0;
    hold_req     = 1'b0;
    rst          = 1'b1;
    write_enable = 1'b0;
    write_index  = REG_CHARGE;
    write_data   = '0;
    in_valid     = 1'b0;
    out_stall    = 1'b0;
    first_x = '0; first_y = '0; first_z = '0;
    second_x = '0; second_y = '0; second_z = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: q is zero, so only the zero flag and zeros come back
    for (int i = 0; i < 30; i++) send_pair(random_pair());
    drain();

    // corner pairs under a unit charge
    write_reg(REG_CHARGE, One);
    write_reg(REG_SHIFT, 32'h0000_8000);
    write_reg(RegUnused, 32'hDEAD_BEEF);   // dropped
    corner = '{
      mk_pair(0, 0, 0, 0, 0, 0),
      mk_pair(Max, Min, 5, Max, Min, 5),
      mk_pair(0, 0, 0, 1, 0, 0),
      mk_pair(0, 0, 0, -1, -1, -1),
      mk_pair(0, 0, 0, One, 0, 0),
      mk_pair(0, 0, 0, 0, -One, 0),
      mk_pair(0, 0, 0, 0, 0, One),
      mk_pair(Min, Min, Min, Max, Max, Max),
      mk_pair(Max, Max, Max, Min, Min, Min),
      mk_pair(Min, 0, 0, Max, 0, 0),
      mk_pair(0, Max, 0, 0, Min, 0),
      mk_pair(0, 0, 0, 3, 4, 0),
      mk_pair(-One, -One, -One, One, One, One),
      mk_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
              32'h1234_5679, 32'h9ABC_DEF0, 32'h0F0F_0F0F),
      mk_pair(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
              32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555),
      mk_pair(0, 0, 0, 32'h0000_0002, 32'h0000_0002, 32'h0000_0001)
    };
    foreach (corner[i]) send_pair(corner[i]);
    // sender pauses until everything is back
    drain();

    charges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
                $urandom(), $urandom(), 32'h0000_0001, $urandom()};
    shifts  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_2345, 32'h0000_0000,
                $urandom(), 32'hFFFF_FFFF, $urandom(), $urandom()};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CHARGE, charges[ph]);
      write_reg(REG_SHIFT, shifts[ph]);
      calm = (ph == 2);
      if (ph == 4) hold_req <= 1'b1;
      foreach (corner[i]) if (ph < 3) send_pair(corner[i]);
      for (int i = 0; i < 220; i++) send_pair(random_pair());
      calm = 1'b0;
      drain();
    end

    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/cpf_pkg.sv
rtl/cpf_isqrt.sv
rtl/cpf_div_pipe.sv
rtl/coulomb_pair_force_unit.sv
tb/sv/testbench.sv
